// ----- src/conv3x3_pkg.sv -----
`default_nettype none

package conv3x3_pkg;

	localparam int PIX_W      = 8;
	localparam int MODE_W     = 2;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

	localparam logic [MODE_W-1:0] MODE_SMOOTH       = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BLUR         = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SHARPEN      = 2'd2;
	localparam logic [MODE_W-1:0] MODE_MEAN_REMOVAL = 2'd3;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd1024;

	localparam int SUM_W       = 14;
	localparam int MAG_W       = 12;
	localparam int RECIP_W     = 17;
	localparam int RECIP_SHIFT = 16;
	localparam int PROD_W      = MAG_W + RECIP_W;
	localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

	localparam int RES_DEPTH = 8;
	localparam int RES_AW    = 3;
	localparam int RES_CW    = RES_AW + 1;

	// Index 0 is the top row of the column, index 2 the bottom row.
	typedef logic [2:0][PIX_W-1:0] pix_col_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	typedef struct packed {
		logic has_top;
		logic has_mid;
		logic col_first;
		logic row_end;
		logic pad;
		logic emit_main;
		logic emit_edge;
	} item_ctl_t;

	typedef struct packed {
		logic              end_of_frame;
		logic              last_of_run;
		logic [PIX_W-1:0]  out_pixel;
	} result_t;

	function automatic sum_t ext_pix(input logic [PIX_W-1:0] v);
		return sum_t'({{(SUM_W-PIX_W){1'b0}}, v});
	endfunction

	// All four kernels are symmetric, so only corner, edge and center groups matter.
	function automatic sum_t kernel_sum(input logic [MODE_W-1:0] mode, input pix_col_t left,
			input pix_col_t mid, input pix_col_t right);
		sum_t corners;
		sum_t edges;
		sum_t center;
		sum_t acc;
		corners = ext_pix(left[0]) + ext_pix(left[2]) + ext_pix(right[0]) + ext_pix(right[2]);
		edges   = ext_pix(left[1]) + ext_pix(right[1]) + ext_pix(mid[0]) + ext_pix(mid[2]);
		center  = ext_pix(mid[1]);
		unique case (mode)
			MODE_SMOOTH:       acc = corners + edges + center;
			MODE_BLUR:         acc = corners + (edges <<< 1) + (center <<< 2);
			MODE_SHARPEN:      acc = (center <<< 3) + (center <<< 1) + center - (edges <<< 1);
			MODE_MEAN_REMOVAL: acc = (center <<< 3) + center - edges - corners;
		endcase
		return acc;
	endfunction

	// Reciprocals scaled by 2^16; exact for every non-negative sum below 2^15.
	function automatic logic [RECIP_W-1:0] recip(input logic [MODE_W-1:0] mode);
		logic [RECIP_W-1:0] m;
		unique case (mode)
			MODE_SMOOTH:       m = 17'd7282;
			MODE_BLUR:         m = 17'd4096;
			MODE_SHARPEN:      m = 17'd21846;
			MODE_MEAN_REMOVAL: m = 17'd65536;
		endcase
		return m;
	endfunction

	// Negative sums truncate to zero or below and clamp to zero.
	function automatic logic [PIX_W-1:0] scale_clamp(input logic [MODE_W-1:0] mode,
			input sum_t s);
		logic [MAG_W-1:0]  mag;
		logic [PROD_W-1:0] prod;
		logic [QUOT_W-1:0] quot;
		logic [PIX_W-1:0]  res;
		mag  = s[SUM_W-1] ? '0 : s[MAG_W-1:0];
		prod = PROD_W'(mag) * PROD_W'(recip(mode));
		quot = prod[PROD_W-1:RECIP_SHIFT];
		if (quot > QUOT_W'(255)) begin
			res = '1;
		end else begin
			res = quot[PIX_W-1:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ----- src/conv3x3_image_filter.sv -----
`default_nettype none

// Channel  | Direction | Request on            | Payload
// ---------+-----------+-----------------------+------------------------------------------
// cfg      | in        | cfg_valid & cfg_ready | cfg_index (register), cfg_data (value)
// s_axis   | in        | tvalid & tready       | tdata = pixel
// m_axis   | out       | tvalid & tready       | tdata = out_pixel, tlast = last_of_run,
//          |           |                       | tuser = end_of_frame
//
// A pixel is taken per cycle unless stalled; results pass s1, s2 and s3 to the output queue.
// A row end after row 0 gives two results if wider than one, so later rows yield one result
// per pixel and the sustained rate stays at one per cycle, set by the single line buffer port
// pair. The input stalls only when the eight-entry result queue, counting results still in
// the pipeline, has fewer than two free places. Reset clears counters, window and queue
// state; the line buffer is not cleared, since rows above the image are masked to zero.
module conv3x3_image_filter #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [conv3x3_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [conv3x3_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [conv3x3_pkg::PIX_W-1:0]       s_axis_tdata,   // [7:0] pixel
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [conv3x3_pkg::PIX_W-1:0]       m_axis_tdata,   // [7:0] out_pixel
	output logic                                m_axis_tlast,
	output logic                                m_axis_tuser    // [0] end_of_frame
);

	import conv3x3_pkg::*;

	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CMP_W = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;
	localparam logic [CMP_W-1:0] MAX_W_C = CMP_W'(MAX_WIDTH);

	logic [MODE_W-1:0]   mode_q;
	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;

	logic [COL_W-1:0]    col_q;
	logic [HEIGHT_W-1:0] row_q;
	logic [RES_CW-1:0]   used_q;

	logic [CMP_W-1:0]    width_ext;
	logic [CMP_W-1:0]    eff_w;
	logic [CMP_W-1:0]    col_next_ext;
	logic [HEIGHT_W-1:0] eff_h;
	logic                in_acc;
	item_ctl_t           ctl0;
	logic [1:0]          n_res0;
	logic [1:0]          n_res_acc;
	logic [PIX_W-1:0]    pix0;

	logic [2*PIX_W-1:0]  line_mem [MAX_WIDTH];
	logic [2*PIX_W-1:0]  rd_data_s1;
	logic [2*PIX_W-1:0]  byp_data_s1;
	logic                byp_s1;
	logic                v_s1;
	item_ctl_t           ctl_s1;
	logic [PIX_W-1:0]    pix_s1;
	logic [COL_W-1:0]    addr_s1;

	logic [2*PIX_W-1:0]  rd_word;
	logic [2*PIX_W-1:0]  wr_data;
	logic [PIX_W-1:0]    top_pix;
	logic [PIX_W-1:0]    mid_pix;
	pix_col_t            col_new;
	pix_col_t            col_a;
	pix_col_t            col_b;
	pix_col_t            win_mid_q;
	pix_col_t            win_new_q;

	logic                v_s2;
	item_ctl_t           ctl_s2;
	pix_col_t            left_s2;
	pix_col_t            mid_s2;
	pix_col_t            right_s2;

	logic                v_s3;
	item_ctl_t           ctl_s3;
	sum_t                sum_main_s3;
	sum_t                sum_edge_s3;

	result_t             res_main;
	result_t             res_edge;
	result_t             res_first;
	logic [1:0]          n_push;
	logic                pop;
	result_t             res_fifo [RES_DEPTH];
	logic [RES_AW-1:0]   wr_ptr_q;
	logic [RES_AW-1:0]   rd_ptr_q;
	logic [RES_CW-1:0]   cnt_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_SMOOTH;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FILTER_MODE:  mode_q   <= cfg_data[MODE_W-1:0];
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		width_ext = CMP_W'(width_q);
		if (width_ext == '0) begin
			eff_w = CMP_W'(1);
		end else if (width_ext > MAX_W_C) begin
			eff_w = MAX_W_C;
		end else begin
			eff_w = width_ext;
		end
		eff_h = (height_q == '0) ? HEIGHT_W'(1) : height_q;
		col_next_ext = CMP_W'(col_q) + CMP_W'(1);

		ctl0.has_top   = row_q > HEIGHT_W'(1);
		ctl0.has_mid   = row_q != '0;
		ctl0.col_first = col_q == '0;
		ctl0.row_end   = col_next_ext >= eff_w;
		ctl0.pad       = row_q >= eff_h;
		ctl0.emit_main = ctl0.has_mid && !ctl0.col_first;
		ctl0.emit_edge = ctl0.has_mid && ctl0.row_end;

		n_res0 = {1'b0, ctl0.emit_main} + {1'b0, ctl0.emit_edge};
		pix0   = ctl0.pad ? '0 : s_axis_tdata;
	end

	assign s_axis_tready = used_q <= RES_CW'(RES_DEPTH - 2);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign n_res_acc     = in_acc ? n_res0 : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			used_q <= '0;
		end else begin
			if (in_acc) begin
				if (ctl0.row_end) begin
					col_q <= '0;
					row_q <= ctl0.pad ? '0 : row_q + HEIGHT_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
			used_q <= used_q + RES_CW'(n_res_acc) - RES_CW'(pop);
		end
	end

	// Each entry holds the row two above in the upper byte and the row just above below it.
	always_comb begin
		rd_word = byp_s1 ? byp_data_s1 : rd_data_s1;
		top_pix = ctl_s1.has_top ? rd_word[2*PIX_W-1:PIX_W] : '0;
		mid_pix = ctl_s1.has_mid ? rd_word[PIX_W-1:0] : '0;
		wr_data = {rd_word[PIX_W-1:0], pix_s1};
		col_new = {pix_s1, mid_pix, top_pix};
		col_a   = ctl_s1.col_first ? '0 : win_mid_q;
		col_b   = ctl_s1.col_first ? '0 : win_new_q;
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			line_mem[addr_s1] <= wr_data;
		end
		if (in_acc) begin
			rd_data_s1 <= line_mem[col_q];
		end
	end

	// A read issued while the previous pixel writes the same entry takes the new data.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			byp_data_s1 <= wr_data;
			ctl_s1      <= ctl0;
			pix_s1      <= pix0;
			addr_s1     <= col_q;
		end
		if (v_s1) begin
			ctl_s2   <= ctl_s1;
			left_s2  <= col_a;
			mid_s2   <= col_b;
			right_s2 <= col_new;
		end
		if (v_s2) begin
			ctl_s3      <= ctl_s2;
			sum_main_s3 <= kernel_sum(mode_q, left_s2, mid_s2, right_s2);
			sum_edge_s3 <= kernel_sum(mode_q, mid_s2, right_s2, '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			byp_s1    <= 1'b0;
			win_mid_q <= '0;
			win_new_q <= '0;
		end else begin
			v_s1 <= in_acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (in_acc) begin
				byp_s1 <= v_s1 && (addr_s1 == col_q);
			end
			if (v_s1) begin
				win_mid_q <= col_b;
				win_new_q <= col_new;
			end
		end
	end

	always_comb begin
		res_main.out_pixel    = scale_clamp(mode_q, sum_main_s3);
		res_main.last_of_run  = !ctl_s3.row_end;
		res_main.end_of_frame = 1'b0;
		res_edge.out_pixel    = scale_clamp(mode_q, sum_edge_s3);
		res_edge.last_of_run  = 1'b1;
		res_edge.end_of_frame = ctl_s3.pad;
		res_first = ctl_s3.emit_main ? res_main : res_edge;
		n_push = v_s3 ? ({1'b0, ctl_s3.emit_main} + {1'b0, ctl_s3.emit_edge}) : 2'd0;
	end

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			res_fifo[wr_ptr_q] <= res_first;
		end
		if (n_push == 2'd2) begin
			res_fifo[wr_ptr_q + RES_AW'(1)] <= res_edge;
		end
	end

	assign m_axis_tvalid = cnt_q != '0;
	assign pop           = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata  = res_fifo[rd_ptr_q].out_pixel;
	assign m_axis_tlast  = res_fifo[rd_ptr_q].last_of_run;
	assign m_axis_tuser  = res_fifo[rd_ptr_q].end_of_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RES_AW'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RES_AW'(1);
			end
			cnt_q <= cnt_q + RES_CW'(n_push) - RES_CW'(pop);
		end
	end

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`default_nettype none

module tb_top;

	import conv3x3_pkg::*;

	localparam int LINE_DEPTH   = 1024;
	localparam int DRAIN_CYCLES = 16;
	localparam int RANDOM_ITEMS = 900;

	typedef logic [2:0][2:0][PIX_W-1:0] window_t;
	typedef enum logic [1:0] {RX_OPEN, RX_PATCHY, RX_CHOKED} rx_style_t;

	logic                  clk;
	logic                  arst_n        = 1'b0;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [PIX_W-1:0]      s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [PIX_W-1:0]      m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  m_axis_tuser;

	conv3x3_image_filter #(
		.MAX_WIDTH(LINE_DEPTH)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Filter state as the block should hold it.
	logic [MODE_W-1:0]   cur_mode   = MODE_SMOOTH;
	logic [WIDTH_W-1:0]  cur_width  = WIDTH_RESET;
	logic [HEIGHT_W-1:0] cur_height = HEIGHT_RESET;
	logic [PIX_W-1:0]    rows_above   [LINE_DEPTH];
	logic [PIX_W-1:0]    rows_current [LINE_DEPTH];
	window_t             win      = '0;
	logic [9:0]          col_cnt  = '0;
	logic [12:0]         row_cnt  = '0;

	result_t   expected_pixels[$];
	int        mismatches  = 0;
	int        items_sent  = 0;
	int        burst_left  = 0;
	rx_style_t rx_style    = RX_OPEN;
	int        rx_phase_left = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#40000000;
		$display("Mismatches found");
		$finish;
	end

	function automatic int tap_weight(input logic [MODE_W-1:0] mode, input int a, input int b);
		bit corner;
		bit center;
		corner = (a != 1) && (b != 1);
		center = (a == 1) && (b == 1);
		case (mode)
			MODE_SMOOTH:  return 1;
			MODE_BLUR:    return center ? 4 : (corner ? 1 : 2);
			MODE_SHARPEN: return center ? 11 : (corner ? 0 : -2);
			default:      return center ? 9 : -1;
		endcase
	endfunction

	function automatic int tap_divisor(input logic [MODE_W-1:0] mode);
		case (mode)
			MODE_SMOOTH:  return 9;
			MODE_BLUR:    return 16;
			MODE_SHARPEN: return 3;
			default:      return 1;
		endcase
	endfunction

	function automatic logic [PIX_W-1:0] convolve(input logic [MODE_W-1:0] mode,
			input window_t w);
		int acc;
		int a;
		int b;
		acc = 0;
		for (a = 0; a < 3; a++) begin
			for (b = 0; b < 3; b++) begin
				acc += int'(w[2-a][2-b]) * tap_weight(mode, a, b);
			end
		end
		acc = acc / tap_divisor(mode);
		if (acc < 0) begin
			acc = 0;
		end
		if (acc > 255) begin
			acc = 255;
		end
		return acc[PIX_W-1:0];
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixel();
		case ($urandom_range(0, 9))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return PIX_W'($urandom_range(0, 15));
			3:       return PIX_W'($urandom_range(240, 255));
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic predict_filter(input logic [PIX_W-1:0] pix);
		int         w_eff;
		int         h_eff;
		int         idx;
		bit         pad;
		bit         last;
		int         k;
		window_t    spill_win;
		result_t    res;
		logic [PIX_W-1:0] p;
		if (cur_width == 0) begin
			w_eff = 1;
		end else if (cur_width > LINE_DEPTH) begin
			w_eff = LINE_DEPTH;
		end else begin
			w_eff = int'(cur_width);
		end
		h_eff = (cur_height == 0) ? 1 : int'(cur_height);
		pad = int'(row_cnt) >= h_eff;
		p = pad ? '0 : pix;
		idx = int'(col_cnt);
		if (col_cnt == 0) begin
			win = '0;
		end
		for (k = 0; k < 3; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = win[k][2];
		end
		// Rows above the top of the image read as zero whatever the buffers hold.
		win[0][2] = (row_cnt >= 2) ? rows_above[idx] : '0;
		win[1][2] = (row_cnt >= 1) ? rows_current[idx] : '0;
		win[2][2] = p;
		rows_above[idx]   = rows_current[idx];
		rows_current[idx] = p;
		last = int'(col_cnt) + 1 >= w_eff;
		if (row_cnt >= 1 && col_cnt >= 1) begin
			res.out_pixel    = convolve(cur_mode, win);
			res.last_of_run  = !last;
			res.end_of_frame = 1'b0;
			expected_pixels.push_back(res);
		end
		if (row_cnt >= 1 && last) begin
			for (k = 0; k < 3; k++) begin
				spill_win[k][0] = win[k][1];
				spill_win[k][1] = win[k][2];
				spill_win[k][2] = '0;
			end
			res.out_pixel    = convolve(cur_mode, spill_win);
			res.last_of_run  = 1'b1;
			res.end_of_frame = pad;
			expected_pixels.push_back(res);
		end
		if (last) begin
			col_cnt = '0;
			row_cnt = pad ? '0 : row_cnt + 1'b1;
		end else begin
			col_cnt = col_cnt + 1'b1;
		end
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] pix);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 60);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pix;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		predict_filter(pix);
	endtask

	task automatic finish_frame();
		do send_pixel(pick_pixel()); while (row_cnt != 0 || col_cnt != 0);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_FILTER_MODE:  cur_mode   = val[MODE_W-1:0];
			REG_IMAGE_WIDTH:  cur_width  = val[WIDTH_W-1:0];
			REG_IMAGE_HEIGHT: cur_height = val[HEIGHT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic test_zero_size_reset_mode();
		write_reg(REG_IMAGE_WIDTH, '0);
		write_reg(REG_IMAGE_HEIGHT, '0);
		send_pixel(8'hFF);
		send_pixel(PIX_W'($urandom_range(0, 255)));
	endtask

	task automatic test_kernels();
		wait_idle();
		write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_BLUR));
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(3));
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(2));
		repeat (6) send_pixel(8'hFF);
		repeat (3) send_pixel(PIX_W'($urandom_range(1, 255)));
		wait_idle();
		write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_SHARPEN));
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(2));
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(1));
		send_pixel(8'hFF);
		send_pixel(8'h00);
		repeat (2) send_pixel(PIX_W'($urandom_range(1, 255)));
		wait_idle();
		write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_MEAN_REMOVAL));
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(3));
		send_pixel(8'h00);
		send_pixel(8'hFF);
		send_pixel(8'h00);
		repeat (3) send_pixel(PIX_W'($urandom_range(1, 255)));
	endtask

	task automatic test_midframe_writes();
		wait_idle();
		write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_SMOOTH));
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(6));
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(4));
		repeat (10) send_pixel(pick_pixel());
		wait_idle();
		// The column already lies past the new width, so the next pixel ends the row.
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(3));
		repeat (5) send_pixel(pick_pixel());
		wait_idle();
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(3));
		send_pixel(pick_pixel());
		wait_idle();
		write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_SHARPEN));
		finish_frame();
		finish_frame();
	endtask

	task automatic test_size_extremes();
		wait_idle();
		write_reg(REG_FILTER_MODE, CFG_DATA_W'($urandom_range(0, 3)));
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(2047));
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(1));
		// The first row ends at the line buffer depth; the padding row is then kept short.
		repeat (LINE_DEPTH) send_pixel(pick_pixel());
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(5));
		finish_frame();
		wait_idle();
		write_reg(REG_FILTER_MODE, CFG_DATA_W'($urandom_range(0, 3)));
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(1));
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(4096));
		repeat (8) send_pixel(pick_pixel());
		wait_idle();
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(2));
		finish_frame();
	endtask

	task automatic test_random_frames();
		int start_count;
		int w;
		int h;
		int w_eff;
		int frame_len;
		start_count = items_sent;
		while (items_sent - start_count < RANDOM_ITEMS) begin
			wait_idle();
			case ($urandom_range(0, 19))
				0: begin
					w = $urandom_range(65, 300);
					h = $urandom_range(0, 1);
				end
				1, 2, 3: begin
					w = $urandom_range(17, 64);
					h = $urandom_range(1, 4);
				end
				default: begin
					w = $urandom_range(0, 16);
					h = $urandom_range(0, 10);
				end
			endcase
			write_reg(REG_FILTER_MODE, CFG_DATA_W'($urandom_range(0, 3)));
			write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
			write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
			w_eff = (w == 0) ? 1 : w;
			frame_len = ((h == 0 ? 1 : h) + 1) * w_eff;
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, frame_len - 1)) send_pixel(pick_pixel());
				wait_idle();
				// Widths only shrink inside a frame so every buffer entry read was written.
				case ($urandom_range(0, 2))
					0:       write_reg(REG_FILTER_MODE, CFG_DATA_W'($urandom_range(0, 3)));
					1:       write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(0, 8)));
					default: write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(0, w_eff)));
				endcase
			end
			finish_frame();
		end
	endtask

	always @(posedge clk) begin
		if (rx_phase_left == 0) begin
			rx_style      <= rx_style_t'($urandom_range(0, 2));
			rx_phase_left <= $urandom_range(20, 200);
		end else begin
			rx_phase_left <= rx_phase_left - 1;
		end
		case (rx_style)
			RX_OPEN:   m_axis_tready <= 1'b1;
			RX_PATCHY: m_axis_tready <= ($urandom_range(0, 9) < 6);
			default:   m_axis_tready <= ($urandom_range(0, 19) == 0);
		endcase
	end

	always @(posedge clk) begin
		result_t exp_res;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_pixels.size() == 0) begin
				$error("result request with no pending expectation: out_pixel %0d", m_axis_tdata);
				mismatches++;
			end else begin
				exp_res = expected_pixels.pop_front();
				if (m_axis_tdata !== exp_res.out_pixel) begin
					$error("out_pixel: expected %0d, actual %0d", exp_res.out_pixel, m_axis_tdata);
					mismatches++;
				end
				if (m_axis_tlast !== exp_res.last_of_run) begin
					$error("last_of_run: expected %0d, actual %0d", exp_res.last_of_run,
						m_axis_tlast);
					mismatches++;
				end
				if (m_axis_tuser !== exp_res.end_of_frame) begin
					$error("end_of_frame: expected %0d, actual %0d", exp_res.end_of_frame,
						m_axis_tuser);
					mismatches++;
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < LINE_DEPTH; i++) begin
			rows_above[i]   = '0;
			rows_current[i] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_size_reset_mode();
		test_kernels();
		test_midframe_writes();
		test_size_extremes();
		test_random_frames();
		wait_idle();
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

`default_nettype wire
